@@ hw/rtl/sle_pkg.sv @@
// Shared types and constants for the sequential list engine.
`timescale 1ns / 1ps

package sle_pkg;

  localparam int unsigned SLE_CAPACITY = 64;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_LOCATE = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_RANGE   = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS_PUT,
    ST_DEL,
    ST_LOC,
    ST_RD,
    ST_DONE
  } state_e;

endpackage

@@ hw/rtl/sle_store.sv @@
// Entry memory of the list engine: one write port and one registered read port.
`timescale 1ns / 1ps

module sle_store
  import sle_pkg::*;
#(
  parameter int unsigned CAPACITY = SLE_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(CAPACITY)-1:0] wr_addr_i,
  input  logic [31:0]                 wr_data_i,
  input  logic                        rd_en_i,
  input  logic [$clog2(CAPACITY)-1:0] rd_addr_i,
  output logic [31:0]                 rd_data_o
);

  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/sequential_list_engine.sv @@
// Top level of the sequential list engine: operation sequencer and result register.
//
//  channel   direction  tdata fields (lowest bit first)
//  s_axis    in         func[1:0], position[9:2], value[41:10], zero fill to 48
//  m_axis    out        status[1:0], found_position[9:2], read_value[41:10],
//                       list_length[49:42], zero fill to 56
//
// One item is taken at a time; the entry memory has one registered read port.
// A read goes through ST_RD, an insert through ST_INS once per entry moved and then ST_INS_PUT,
// a delete through ST_DEL once per entry moved, a locate through ST_LOC once per entry compared;
// all then reach ST_DONE, as a rejected item does at once, and ST_DONE loads the result register.
// A new item can follow even while that result waits on a stalled output; that item then
// holds its own result until the output frees. Reset empties the list; the memory is not cleared.
`timescale 1ns / 1ps

module sequential_list_engine
  import sle_pkg::*;
#(
  parameter int unsigned CAPACITY = SLE_CAPACITY
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // func, position, value
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata   // status, found_position, read_value, list_length
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [7:0]    pos_q, pos_d;
  logic [31:0]   val_q, val_d;
  logic [AW-1:0] k_q, k_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0]    st_q, st_d;
  logic [7:0]    found_q, found_d;
  logic [31:0]   rdval_q, rdval_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   wr_data, rd_data;

  logic [1:0]  in_func;
  logic [7:0]  in_pos, in_pos_m1, pos_m1;
  logic [31:0] in_val;
  logic [8:0]  pos9, cnt9;
  logic [7:0]  k8, cnt8;

  logic accept, ins_bad, ins_full, ins_move, pos_bad, del_move;
  logic ins_more, del_more, loc_hit, loc_more, out_free;

  assign in_func   = s_axis_tdata[1:0];
  assign in_pos    = s_axis_tdata[9:2];
  assign in_val    = s_axis_tdata[41:10];
  assign in_pos_m1 = in_pos - 8'd1;
  assign pos_m1    = pos_q - 8'd1;
  assign pos9      = {1'b0, in_pos};
  assign cnt9      = 9'(cnt_q);
  assign k8        = 8'(k_q);
  assign cnt8      = 8'(cnt_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign ins_bad  = (in_pos == 8'd0) || (pos9 > cnt9 + 9'd1);
  assign ins_full = (cnt_q == CW'(CAPACITY));
  assign ins_move = (pos9 <= cnt9);
  assign pos_bad  = (in_pos == 8'd0) || (pos9 > cnt9);
  assign del_move = (pos9 < cnt9);
  assign ins_more = (k8 > pos_q);
  assign del_more = (k8 + 8'd1 < cnt8);
  assign loc_hit  = (rd_data == val_q);
  assign loc_more = (k8 + 8'd1 < cnt8);
  assign out_free = !out_valid_q || m_axis_tready;

  sle_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func)
            FN_INSERT: begin
              if (ins_bad || ins_full) begin
                state_d = ST_DONE;
              end else if (ins_move) begin
                state_d = ST_INS;
              end else begin
                state_d = ST_INS_PUT;
              end
            end
            FN_DELETE: begin
              state_d = (!pos_bad && del_move) ? ST_DEL : ST_DONE;
            end
            FN_LOCATE: begin
              state_d = (cnt_q == '0) ? ST_DONE : ST_LOC;
            end
            FN_READ: begin
              state_d = pos_bad ? ST_DONE : ST_RD;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_INS:     state_d = ins_more ? ST_INS : ST_INS_PUT;
      ST_INS_PUT: state_d = ST_DONE;
      ST_DEL:     state_d = del_more ? ST_DEL : ST_DONE;
      ST_LOC:     state_d = (!loc_hit && loc_more) ? ST_LOC : ST_DONE;
      ST_RD:      state_d = ST_DONE;
      ST_DONE:    state_d = out_free ? ST_IDLE : ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = k_q;
    wr_data     = rd_data;
    rd_en       = 1'b0;
    rd_addr     = k_q;
    pos_d       = pos_q;
    val_d       = val_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    st_d        = st_q;
    found_d     = found_q;
    rdval_d     = rdval_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d   = in_pos;
          val_d   = in_val;
          st_d    = STAT_OK;
          found_d = 8'd0;
          rdval_d = 32'd0;
          unique case (in_func)
            FN_INSERT: begin
              if (ins_bad) begin
                st_d = STAT_RANGE;
              end else if (ins_full) begin
                st_d = STAT_FULL;
              end else begin
                cnt_d = cnt_q + CW'(1);
                if (ins_move) begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(cnt_q - CW'(1));
                  k_d     = AW'(cnt_q);
                end
              end
            end
            FN_DELETE: begin
              if (pos_bad) begin
                st_d = STAT_RANGE;
              end else begin
                cnt_d = cnt_q - CW'(1);
                if (del_move) begin
                  rd_en   = 1'b1;
                  rd_addr = in_pos[AW-1:0];
                  k_d     = in_pos_m1[AW-1:0];
                end
              end
            end
            FN_LOCATE: begin
              st_d = STAT_MISSING;
              if (cnt_q != '0) begin
                rd_en   = 1'b1;
                rd_addr = '0;
                k_d     = '0;
              end
            end
            FN_READ: begin
              if (pos_bad) begin
                st_d = STAT_RANGE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = in_pos_m1[AW-1:0];
              end
            end
            default: st_d = STAT_RANGE;
          endcase
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = k_q;
        wr_data = rd_data;
        if (ins_more) begin
          rd_en   = 1'b1;
          rd_addr = k_q - AW'(2);
          k_d     = k_q - AW'(1);
        end
      end
      ST_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_m1[AW-1:0];
        wr_data = val_q;
      end
      ST_DEL: begin
        wr_en   = 1'b1;
        wr_addr = k_q;
        wr_data = rd_data;
        if (del_more) begin
          rd_en   = 1'b1;
          rd_addr = k_q + AW'(2);
          k_d     = k_q + AW'(1);
        end
      end
      ST_LOC: begin
        if (loc_hit) begin
          st_d    = STAT_OK;
          found_d = k8 + 8'd1;
        end else if (loc_more) begin
          rd_en   = 1'b1;
          rd_addr = k_q + AW'(1);
          k_d     = k_q + AW'(1);
        end
      end
      ST_RD: begin
        rdval_d = rd_data;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, cnt8, rdval_q, found_q, st_q};
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    val_q      <= val_d;
    k_q        <= k_d;
    st_q       <= st_d;
    found_q    <= found_d;
    rdval_q    <= rdval_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
